// ----- hw/rtl/apts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apts_pkg: shared types and constants
// controller/datapath command and status structs, register indexes, constants
// ----------------------------------------------------------------------------
package apts_pkg;

  localparam int unsigned STALL_US_DEF         = 200000;
  localparam int unsigned HOLD_GIVE_UP_US_DEF  = 2000000;
  localparam int unsigned JUMP_ARM_PACKETS_DEF = 8;
  localparam int unsigned CHANNELS_DEF         = 2;
  localparam int unsigned MAX_PAYLOAD_DEF      = 1024;

  localparam int unsigned US_PER_S  = 1000000;
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned SLEW_STOP_DIV = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 26;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_HZ        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_US        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEADY_US      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GIVE_UP_US     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIM_US    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_LIM_US    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP_US   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_STARVE_MS = 3'd7;

  localparam logic [1:0] ST_SCHEDULED = 2'd0;
  localparam logic [1:0] ST_OVERSIZE  = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;
  localparam logic [1:0] ST_WAITING   = 2'd3;

  // width of the shared divider (dividend)
  localparam int unsigned DIV_W = 64;

  typedef struct packed {
    logic load;      // capture packet and do screening / timeline decision
    logic lvl_start; // start buffer level division
    logic lvl_done;  // apply steering with level result
    logic adv_start; // start advance division
    logic adv_done;  // commit advance and form result
  } apts_cmd_t;

  typedef struct packed {
    logic need_level; // hard jump path needs the buffer level
    logic early;      // result already final after load (non-scheduled)
    logic div_busy;
  } apts_sts_t;

endpackage

// ----- hw/rtl/audio_playout_timeline_scheduler.sv -----
`timescale 1ns / 1ps
// sequencing: a dropped, ignored or waiting packet skips the divider; a scheduled
//   one runs the advance division, preceded by a level division on a hard jump
// flow: one packet at a time, the next is taken only after the result is accepted,
//   and both divisions share one 64-step radix-2 divider
// reset: synchronous rst clears timeline state, loads register defaults
// ----------------------------------------------------------------------------
// audio_playout_timeline_scheduler: top level
// schedules arriving audio packets onto a play timeline
// ----------------------------------------------------------------------------
module audio_playout_timeline_scheduler #(
  parameter int unsigned STALL_US         = apts_pkg::STALL_US_DEF,
  parameter int unsigned HOLD_GIVE_UP_US  = apts_pkg::HOLD_GIVE_UP_US_DEF,
  parameter int unsigned JUMP_ARM_PACKETS = apts_pkg::JUMP_ARM_PACKETS_DEF,
  parameter int unsigned CHANNELS         = apts_pkg::CHANNELS_DEF,
  parameter int unsigned MAX_PAYLOAD      = apts_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [apts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [apts_pkg::CFG_DATA_W-1:0] cfg_data,
  // packet transaction in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [61:0] now_us,
  input  logic [15:0] pkt_len,
  input  logic [15:0] frames,
  input  logic        marker,
  input  logic        link_up,
  input  logic        underrun_flag,
  input  logic        restart_request,
  input  logic [20:0] ring_fill_bytes,
  input  logic [30:0] sample_pos,
  // result transaction out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] seq_num,
  output logic [61:0] play_time,
  output logic        marker_out,
  output logic        restart_flag,
  output logic        started,
  output logic signed [31:0] boundary_pos,
  output logic [61:0] next_time
);
  apts_pkg::apts_cmd_t cmd;
  apts_pkg::apts_sts_t sts;

  // controller: walks each packet through decision, level and advance steps
  apts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  // datapath: holds all timeline state and the shared divider
  apts_datapath #(
    .STALL_US(STALL_US), .HOLD_GIVE_UP_US(HOLD_GIVE_UP_US),
    .JUMP_ARM_PACKETS(JUMP_ARM_PACKETS), .CHANNELS(CHANNELS),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .now_us(now_us), .pkt_len(pkt_len), .frames(frames),
    .marker(marker), .link_up(link_up), .underrun_flag(underrun_flag),
    .restart_request(restart_request), .ring_fill_bytes(ring_fill_bytes),
    .sample_pos(sample_pos), .status(status), .seq_num(seq_num),
    .play_time(play_time), .marker_out(marker_out),
    .restart_flag(restart_flag), .started(started),
    .boundary_pos(boundary_pos), .next_time(next_time)
  );

  // a result is never offered while a new transaction can be taken
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in_ready and out_valid together");

  // a started timeline always reports a scheduled status
  a_start: assert property (@(posedge clk) disable iff (rst)
    (out_valid && started) |-> (status == apts_pkg::ST_SCHEDULED))
    else $error("started on unscheduled result");

  // non-scheduled results carry no boundary
  a_bnd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != apts_pkg::ST_SCHEDULED) |-> (boundary_pos == -32'sd1))
    else $error("boundary on unscheduled result");

endmodule

// ----- hw/rtl/apts_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apts_divider: radix-2 restoring divider
// one quotient bit per cycle, quotient and remainder held until next start
// ----------------------------------------------------------------------------
module apts_divider #(
  parameter int unsigned NW = apts_pkg::DIV_W,
  parameter int unsigned DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [CW-1:0] count;
  logic [DW:0]   part;
  logic [DW:0]   trial;
  logic [DW-1:0] dvsr;

  always_comb begin
    trial = {rem, quot[NW-1]} - {1'b0, dvsr};
    part  = {rem, quot[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(NW);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem  <= trial[DW-1:0];
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= part[DW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/apts_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apts_datapath: timeline state and arithmetic
// screening, steady wait, steering, sequence and boundary, play time advance
// ----------------------------------------------------------------------------
module apts_datapath #(
  parameter int unsigned STALL_US         = apts_pkg::STALL_US_DEF,
  parameter int unsigned HOLD_GIVE_UP_US  = apts_pkg::HOLD_GIVE_UP_US_DEF,
  parameter int unsigned JUMP_ARM_PACKETS = apts_pkg::JUMP_ARM_PACKETS_DEF,
  parameter int unsigned CHANNELS         = apts_pkg::CHANNELS_DEF,
  parameter int unsigned MAX_PAYLOAD      = apts_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  apts_pkg::apts_cmd_t cmd,
  output apts_pkg::apts_sts_t sts,
  input  logic                cfg_we,
  input  logic [apts_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [apts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [61:0]         now_us,
  input  logic [15:0]         pkt_len,
  input  logic [15:0]         frames,
  input  logic                marker,
  input  logic                link_up,
  input  logic                underrun_flag,
  input  logic                restart_request,
  input  logic [20:0]         ring_fill_bytes,
  input  logic [30:0]         sample_pos,
  output logic [1:0]          status,
  output logic [31:0]         seq_num,
  output logic [61:0]         play_time,
  output logic                marker_out,
  output logic                restart_flag,
  output logic                started,
  output logic signed [31:0]  boundary_pos,
  output logic [61:0]         next_time
);
  localparam int unsigned DW = 64;
  // divisor for the level: rate * channels * 2 bytes
  localparam int unsigned LVL_DIV_W = 17 + $clog2(CHANNELS * 2 + 1);
  localparam int unsigned JW = 5;

  // configuration
  logic [16:0] rate_hz;
  logic [23:0] lead_us, steady_us, jump_lim_us;
  logic [25:0] give_up_us;
  logic [19:0] slew_lim_us;
  logic [9:0]  slew_step_us;
  logic [13:0] hold_starve_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_hz        <= 17'd44100;
      lead_us        <= 24'd200000;
      steady_us      <= 24'd1000000;
      give_up_us     <= 26'd3000000;
      jump_lim_us    <= 24'd50000;
      slew_lim_us    <= 20'd2000;
      slew_step_us   <= 10'd10;
      hold_starve_ms <= 14'd50;
    end else if (cfg_we) begin
      case (cfg_idx)
        apts_pkg::REG_RATE_HZ:        rate_hz        <= cfg_data[16:0];
        apts_pkg::REG_LEAD_US:        lead_us        <= cfg_data[23:0];
        apts_pkg::REG_STEADY_US:      steady_us      <= cfg_data[23:0];
        apts_pkg::REG_GIVE_UP_US:     give_up_us     <= cfg_data;
        apts_pkg::REG_JUMP_LIM_US:    jump_lim_us    <= cfg_data[23:0];
        apts_pkg::REG_SLEW_LIM_US:    slew_lim_us    <= cfg_data[19:0];
        apts_pkg::REG_SLEW_STEP_US:   slew_step_us   <= cfg_data[9:0];
        apts_pkg::REG_HOLD_STARVE_MS: hold_starve_ms <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  logic [16:0] rate_nz;
  assign rate_nz = (rate_hz == '0) ? 17'd1 : rate_hz;

  // timeline state
  logic [62:0] play_at;
  logic [16:0] play_remainder;
  logic [62:0] last_arrival, steady_since, wait_since, hold_since;
  logic        slewing, restart_pending, recover_pending;
  logic [JW-1:0] jump_countdown;
  logic [31:0] boundary_latch;
  logic [31:0] sequence_cnt;

  // packet capture
  logic [62:0] now_r, target_r;
  logic [15:0] frames_r;
  logic        marker_r, recovered_r, started_r;
  logic [20:0] fill_r;
  logic [30:0] pos_r;

  // shared divider
  logic          div_start, div_busy;
  logic [DW-1:0] div_n, div_q;
  logic [LVL_DIV_W-1:0] div_d;
  logic [LVL_DIV_W-1:0] div_r;

  apts_divider #(.NW(DW), .DW(LVL_DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .busy(div_busy), .quot(div_q), .rem(div_r)
  );

  // steering commit (level known)
  logic starving, held;
  assign starving = div_q < DW'(hold_starve_ms);
  assign held = starving && (hold_since == '0 ||
                $signed(now_r - hold_since) < $signed(63'(HOLD_GIVE_UP_US)));

  // registered products ahead of the divisions
  // a jump clears the remainder in the same cycle as the level result lands
  logic [DW-1:0] lvl_num, adv_num;
  logic [LVL_DIV_W-1:0] lvl_den;
  always_ff @(posedge clk) begin
    lvl_num <= DW'(fill_r) * DW'(apts_pkg::MS_PER_S);
    lvl_den <= LVL_DIV_W'(rate_nz) * LVL_DIV_W'(CHANNELS * 2);
    adv_num <= DW'(frames_r) * DW'(apts_pkg::US_PER_S) +
               DW'((cmd.lvl_done && !held) ? 17'd0 : play_remainder);
  end

  assign div_start = cmd.lvl_start | cmd.adv_start;
  assign div_n = cmd.lvl_start ? lvl_num : adv_num;
  assign div_d = cmd.lvl_start ? lvl_den : LVL_DIV_W'(rate_nz);

  // ------- load stage decision -------
  logic [62:0] now_s, tgt_s;
  logic        oversize, invalid;
  logic        fresh_steady;
  logic [62:0] steady_since_n, wait_since_eff;
  logic        steady_ok;
  logic [62:0] err;
  logic [62:0] mag;
  logic        hard;

  assign now_s = {1'b0, now_us};
  assign tgt_s = now_s + 63'(lead_us);
  assign oversize = pkt_len > 16'(MAX_PAYLOAD);
  assign invalid  = !link_up || pkt_len == '0 || frames == '0;
  assign fresh_steady = (last_arrival == '0) ||
                        ($signed(now_s - last_arrival) > $signed(63'(STALL_US)));
  assign steady_since_n = fresh_steady ? now_s : steady_since;
  assign wait_since_eff = (wait_since == '0) ? now_s : wait_since;
  assign steady_ok = !($signed(now_s - steady_since_n) < $signed(63'(steady_us))) ||
                     !($signed(now_s - wait_since_eff) < $signed(63'(give_up_us)));
  logic        no_tl;
  assign no_tl = recover_pending || underrun_flag || play_at == '0;
  // this packet starts a new timeline
  logic        start_now;
  assign start_now = !oversize && !invalid && no_tl && steady_ok;

  assign err  = play_at - tgt_s;
  assign mag  = err[62] ? (63'd0 - err) : err;
  assign hard = mag > 63'(jump_lim_us);

  logic err_pos_r, hold_path;

  assign sts.need_level = hold_path;
  assign sts.div_busy   = div_busy;
  assign sts.early      = (status != apts_pkg::ST_SCHEDULED);

  // common tail once play_at settled
  logic [JW-1:0] jc_dec;
  logic [31:0]   pos_eff;
  assign pos_eff = started_r ? 32'd0 : {1'b0, pos_r};
  assign jc_dec  = jump_countdown - 1'b1;

  logic [62:0] play_new;
  assign play_new = play_at + div_q[62:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      play_at         <= '0;
      play_remainder  <= '0;
      last_arrival    <= '0;
      steady_since    <= '0;
      wait_since      <= '0;
      hold_since      <= '0;
      slewing         <= 1'b0;
      restart_pending <= 1'b0;
      recover_pending <= 1'b0;
      jump_countdown  <= '0;
      boundary_latch  <= '1;
      sequence_cnt    <= '0;
      status          <= apts_pkg::ST_SCHEDULED;
      hold_path       <= 1'b0;
    end else begin
      if (cmd.load) begin
        hold_path       <= !oversize && !invalid && !no_tl && hard;
        // requests latch on every packet, a start consumes them
        recover_pending <= (recover_pending || underrun_flag) && !start_now;
        restart_pending <= (restart_pending || restart_request) && !start_now;
        now_r <= now_s; target_r <= tgt_s; frames_r <= frames;
        marker_r <= marker; fill_r <= ring_fill_bytes; pos_r <= sample_pos;
        recovered_r <= recover_pending || underrun_flag;
        started_r <= start_now;
        if (oversize) begin
          status <= apts_pkg::ST_OVERSIZE;
        end else if (invalid) begin
          status <= apts_pkg::ST_IGNORED;
        end else begin
          steady_since <= steady_since_n;
          last_arrival <= now_s;
          if (no_tl) begin
            if (!steady_ok) begin
              if (recover_pending || underrun_flag) play_at <= '0;
              wait_since <= wait_since_eff;
              status <= apts_pkg::ST_WAITING;
            end else begin
              wait_since      <= '0;
              status          <= apts_pkg::ST_SCHEDULED;
              play_at         <= tgt_s;
              play_remainder  <= '0;
              boundary_latch  <= '1;
              slewing         <= 1'b0;
            end
          end else begin
            status    <= apts_pkg::ST_SCHEDULED;
            err_pos_r <= !err[62] && err != '0;
            if (!hard) begin
              hold_since <= '0;
              if (mag > 63'(slew_lim_us)) begin
                slewing <= 1'b1;
                play_at <= (!err[62] && err != '0) ? play_at - 63'(slew_step_us)
                                                   : play_at + 63'(slew_step_us);
              end else if (slewing &&
                           mag < 63'(slew_lim_us / 20'(apts_pkg::SLEW_STOP_DIV))) begin
                slewing <= 1'b0;
              end else if (slewing) begin
                play_at <= (!err[62] && err != '0) ? play_at - 63'(slew_step_us)
                                                   : play_at + 63'(slew_step_us);
              end
            end
          end
        end
      end

      if (cmd.lvl_done) begin
        if (held) begin
          if (hold_since == '0) hold_since <= now_r;
          if (slewing) begin
            play_at <= err_pos_r ? play_at - 63'(slew_step_us)
                                 : play_at + 63'(slew_step_us);
          end
        end else begin
          hold_since     <= '0;
          play_at        <= target_r;
          play_remainder <= '0;
          slewing        <= 1'b0;
          jump_countdown <= JW'(JUMP_ARM_PACKETS);
        end
      end

      if (cmd.adv_start) begin
        // sequence, countdown and boundary before the advance
        sequence_cnt <= sequence_cnt + 1'b1;
        seq_num      <= sequence_cnt;
        play_time    <= play_at[61:0];
        marker_out   <= marker_r;
        started      <= started_r;
        restart_flag <= restart_pending || recovered_r ||
                        (jump_countdown != '0 && jc_dec == '0);
        if (jump_countdown != '0) jump_countdown <= jc_dec;
        restart_pending <= 1'b0;
        if ((restart_pending || (jump_countdown != '0 && jc_dec == '0)) &&
            boundary_latch[31]) begin
          boundary_latch <= pos_eff;
        end
      end

      if (cmd.adv_done) begin
        play_at        <= play_new;
        play_remainder <= div_r[16:0];
        next_time      <= play_new[61:0];
        boundary_pos   <= boundary_latch;
      end

      if (cmd.load && (oversize || invalid || (no_tl && !steady_ok))) begin
        seq_num <= '0; play_time <= '0; marker_out <= 1'b0;
        restart_flag <= 1'b0; started <= 1'b0; next_time <= '0;
        boundary_pos <= '1;
      end
    end
  end

endmodule

// ----- hw/rtl/apts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apts_ctrl: sequencing state machine
// handshakes, orders load, level division, advance division and result
// ----------------------------------------------------------------------------
module apts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  apts_pkg::apts_sts_t sts,
  output apts_pkg::apts_cmd_t cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_LVLP  = 3'd2;
  localparam logic [2:0] S_LVL   = 3'd3;
  localparam logic [2:0] S_ADVP  = 3'd4;
  localparam logic [2:0] S_ADV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (sts.early) state_next = S_OUT;
        else if (sts.need_level) state_next = S_LVLP;
        else state_next = S_ADVP;
      end
      S_LVLP: begin
        cmd.lvl_start = 1'b1;
        state_next = S_LVL;
      end
      S_LVL: if (!sts.div_busy) begin
        cmd.lvl_done = 1'b1;
        state_next = S_ADVP;
      end
      S_ADVP: begin
        cmd.adv_start = 1'b1;
        state_next = S_ADV;
      end
      S_ADV: if (!sts.div_busy) begin
        cmd.adv_done = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
